// ===== hdl/n2w_pkg.sv =====
// Shared types, token codes and the binary-to-decimal step for number_to_english_words.
`timescale 1ns / 1ps

package n2w_pkg;

    localparam int NUM_W     = 31;
    localparam int DIGITS    = 10;
    localparam int TOK_W     = 5;
    localparam int GROUPS    = 4;
    localparam int SLOTS     = 5;
    localparam int MASK_W    = GROUPS * SLOTS;
    // two bits per conversion step; the top bit is taken at accept
    localparam int DAB_STEPS = (NUM_W - 1) / 2;
    localparam int STEP_W    = $clog2(DAB_STEPS);

    localparam logic [TOK_W-1:0] TOK_ZERO      = 5'd0;
    localparam logic [TOK_W-1:0] TOK_TEEN_BASE = 5'd10;
    localparam logic [TOK_W-1:0] TOK_TENS_OFS  = 5'd18;
    localparam logic [TOK_W-1:0] TOK_HUNDRED   = 5'd28;
    localparam logic [TOK_W-1:0] TOK_THOUSAND  = 5'd29;
    localparam logic [TOK_W-1:0] TOK_MILLION   = 5'd30;
    localparam logic [TOK_W-1:0] TOK_BILLION   = 5'd31;

    typedef logic [DIGITS-1:0][3:0] t_digits;

    typedef struct packed {
        t_digits digits;
    } t_entry;

    // One shift-add-3 step: correct every digit, then shift one bit in.
    function automatic t_digits dabble1(input t_digits bcd, input logic bit_in);
        t_digits adj;
        for (int i = 0; i < DIGITS; i++) begin
            adj[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
        end
        return t_digits'({adj, bit_in});
    endfunction

endpackage

// ===== hdl/n2w_front.sv =====
// Front end: accepts a number and converts it to ten decimal digits, two bits a cycle.
`timescale 1ns / 1ps

module n2w_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [n2w_pkg::NUM_W-1:0] i_number,
    output logic                      o_busy,
    input  logic                      i_full,
    output logic                      o_push,
    output n2w_pkg::t_entry           o_entry
);
    import n2w_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_HOLD
    } t_state;

    t_state                r_state;
    logic [STEP_W-1:0]     r_cnt;
    logic [NUM_W-2:0]      r_bin;
    t_digits               r_bcd;
    t_digits               n_bcd;
    logic                  accept;
    logic                  last_step;

    assign n_bcd     = dabble1(dabble1(r_bcd, r_bin[NUM_W-2]), r_bin[NUM_W-3]);
    assign o_busy    = (r_state != S_IDLE);
    assign accept    = i_start & ~o_busy;
    assign last_step = (r_state == S_CONV) && (r_cnt == STEP_W'(DAB_STEPS - 1));
    assign o_push    = (last_step || r_state == S_HOLD) && !i_full;
    assign o_entry   = '{digits: (r_state == S_HOLD) ? r_bcd : n_bcd};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_CONV;
                        r_cnt   <= '0;
                        // top bit needs no correction pass
                        r_bcd   <= t_digits'(i_number[NUM_W-1]);
                        r_bin   <= i_number[NUM_W-2:0];
                    end
                end
                S_CONV: begin
                    r_bcd <= n_bcd;
                    r_bin <= {r_bin[NUM_W-4:0], 2'b00};
                    r_cnt <= r_cnt + 1'b1;
                    if (last_step) begin
                        // hold the digits if the queue has no room
                        r_state <= i_full ? S_HOLD : S_IDLE;
                    end
                end
                S_HOLD: begin
                    if (!i_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/n2w_fifo.sv =====
// Two-entry queue of converted digit sets between front and back ends.
`timescale 1ns / 1ps

module n2w_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  n2w_pkg::t_entry i_wdata,
    input  logic            i_pop,
    output n2w_pkg::t_entry o_rdata,
    output logic            o_full,
    output logic            o_empty
);
    import n2w_pkg::*;

    t_entry     r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_rdata = r_mem[r_rp];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

// ===== hdl/n2w_back.sv =====
// Back end: walks the digit groups and emits one word token per cycle while it holds a digit set.
`timescale 1ns / 1ps

module n2w_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_empty,
    input  n2w_pkg::t_entry           i_entry,
    output logic                      o_pop,
    output logic                      o_valid,
    output logic [n2w_pkg::TOK_W-1:0] o_word_token,
    output logic                      o_last_word
);
    import n2w_pkg::*;

    logic                  r_active;
    logic                  r_zero;
    logic [MASK_W-1:0]     r_mask;
    t_digits               r_digits;
    logic                  r_valid;
    logic [TOK_W-1:0]      r_tok;
    logic                  r_last;

    logic [MASK_W-1:0]     load_mask;
    logic [TOK_W-1:0]      toks [MASK_W];
    logic [MASK_W-1:0]     n_mask;
    logic [TOK_W-1:0]      sel_tok;
    logic                  found;
    logic                  emit_last;

    // Slot tokens for each group: digit, Hundred, tens or teen, ones, scale.
    always_comb begin
        logic [3:0] h, t, o;
        load_mask = '0;
        for (int g = 0; g < GROUPS; g++) begin
            toks[g*SLOTS+0] = TOK_ZERO;
            toks[g*SLOTS+1] = TOK_HUNDRED;
            toks[g*SLOTS+2] = TOK_ZERO;
            toks[g*SLOTS+3] = TOK_ZERO;
            toks[g*SLOTS+4] = TOK_ZERO;
        end
        for (int g = 0; g < GROUPS; g++) begin
            if (g == 0) begin
                h = 4'd0;
                t = 4'd0;
                o = i_entry.digits[DIGITS-1];
            end else begin
                h = i_entry.digits[(GROUPS-g)*3-1];
                t = i_entry.digits[(GROUPS-g)*3-2];
                o = i_entry.digits[(GROUPS-g)*3-3];
            end
            load_mask[g*SLOTS+0] = (h != 4'd0);
            load_mask[g*SLOTS+1] = (h != 4'd0);
            load_mask[g*SLOTS+2] = (t != 4'd0);
            load_mask[g*SLOTS+3] = (o != 4'd0) && (t != 4'd1);
            load_mask[g*SLOTS+4] = ((h | t | o) != 4'd0) && (g != GROUPS - 1);
        end
        for (int g = 0; g < GROUPS; g++) begin
            if (g == 0) begin
                h = 4'd0;
                t = 4'd0;
                o = r_digits[DIGITS-1];
            end else begin
                h = r_digits[(GROUPS-g)*3-1];
                t = r_digits[(GROUPS-g)*3-2];
                o = r_digits[(GROUPS-g)*3-3];
            end
            toks[g*SLOTS+0] = {1'b0, h};
            toks[g*SLOTS+2] = (t >= 4'd2) ? TOK_TENS_OFS + {1'b0, t}
                                          : TOK_TEEN_BASE + {1'b0, o};
            toks[g*SLOTS+3] = {1'b0, o};
            case (g)
                0:       toks[g*SLOTS+4] = TOK_BILLION;
                1:       toks[g*SLOTS+4] = TOK_MILLION;
                2:       toks[g*SLOTS+4] = TOK_THOUSAND;
                default: toks[g*SLOTS+4] = TOK_ZERO;
            endcase
        end
    end

    // Pick the first pending slot and drop it from the mask.
    always_comb begin
        found   = 1'b0;
        sel_tok = TOK_ZERO;
        n_mask  = r_mask;
        for (int i = 0; i < MASK_W; i++) begin
            if (r_mask[i] && !found) begin
                found     = 1'b1;
                sel_tok   = toks[i];
                n_mask[i] = 1'b0;
            end
        end
    end

    assign emit_last    = r_zero || (n_mask == '0);
    assign o_pop        = !i_empty && (!r_active || emit_last);
    assign o_valid      = r_valid;
    assign o_word_token = r_tok;
    assign o_last_word  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= r_active;
            if (r_active) begin
                r_tok  <= r_zero ? TOK_ZERO : sel_tok;
                r_last <= emit_last;
                if (emit_last && i_empty) begin
                    r_active <= 1'b0;
                end
            end
            if (o_pop) begin
                r_active <= 1'b1;
                r_digits <= i_entry.digits;
                r_mask   <= load_mask;
                r_zero   <= (load_mask == '0);
            end else if (r_active) begin
                r_mask <= n_mask;
            end
        end
    end

endmodule

// ===== hdl/number_to_english_words.sv =====
// Top level: number to English word tokens, front converter, queue and token emitter.
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+---------------------------------
//  command  | in        | start high while busy low    | i_number[30:0]
//  result   | out       | o_valid strobe, one cycle    | o_word_token[4:0], o_last_word
//
// A number enters the front converter with one bit at accept, then two shift-add-3 steps
// a cycle; a new number is taken only once the converter is idle again. The back end
// emits one token per cycle while it has digits to spell, 1 to 16 tokens per number, the
// first token leaving the back end's output register. A two-entry queue lets the converter
// run ahead. busy stays high during conversion and while converted digits wait for room
// in the queue; results cannot be stalled. Reset clears control state only.
`timescale 1ns / 1ps

module number_to_english_words (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [n2w_pkg::NUM_W-1:0] i_number,
    output logic                      o_valid,
    output logic [n2w_pkg::TOK_W-1:0] o_word_token,
    output logic                      o_last_word
);
    import n2w_pkg::*;

    logic   push;
    logic   pop;
    logic   full;
    logic   empty;
    t_entry wr_entry;
    t_entry rd_entry;

    n2w_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_number (i_number),
        .o_busy   (busy),
        .i_full   (full),
        .o_push   (push),
        .o_entry  (wr_entry)
    );

    n2w_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (wr_entry),
        .i_pop   (pop),
        .o_rdata (rd_entry),
        .o_full  (full),
        .o_empty (empty)
    );

    n2w_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (empty),
        .i_entry      (rd_entry),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .o_word_token (o_word_token),
        .o_last_word  (o_last_word)
    );

endmodule

// ===== tb/number_to_english_words_tb.sv =====
// Testbench for number_to_english_words: spells each number sent and checks every word token.
`timescale 1ns / 1ps

module number_to_english_words_tb;
    import n2w_pkg::*;

    localparam int          STALL_LIMIT = 2000;
    localparam int          TAIL_CYCLES = 40;
    localparam int unsigned NUM_MAX     = 32'd2147483647;
    localparam logic [TOK_W-1:0] TOK_TWENTY = 5'd20;

    typedef struct packed {
        logic [TOK_W-1:0] token;
        logic             last;
    } t_word;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic [NUM_W-1:0] i_number;
    logic             o_valid;
    logic [TOK_W-1:0] o_word_token;
    logic             o_last_word;

    t_word words_due[$];
    t_word reading[$];
    int    err_count;
    int    stall_cycles;

    number_to_english_words u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_number     (i_number),
        .o_valid      (o_valid),
        .o_word_token (o_word_token),
        .o_last_word  (o_last_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Append the words of one three-digit group and its scale word to the reading.
    function automatic void spell_group(input int unsigned grp, input logic [TOK_W-1:0] scale,
                                        input bit scaled);
        int unsigned hund;
        int unsigned rest;
        if (grp == 0) return;
        hund = grp / 100;
        rest = grp % 100;
        if (hund != 0) begin
            reading.push_back('{token: TOK_W'(hund), last: 1'b0});
            reading.push_back('{token: TOK_HUNDRED, last: 1'b0});
        end
        if (rest >= 20) begin
            reading.push_back('{token: TOK_TWENTY + TOK_W'(rest / 10 - 2), last: 1'b0});
            if (rest % 10 != 0)
                reading.push_back('{token: TOK_W'(rest % 10), last: 1'b0});
        end else if (rest != 0) begin
            reading.push_back('{token: TOK_W'(rest), last: 1'b0});
        end
        if (scaled)
            reading.push_back('{token: scale, last: 1'b0});
    endfunction

    // Work out the full reading of a number and queue its words.
    function automatic void spell_number(input logic [NUM_W-1:0] num);
        int unsigned v;
        v = 32'(num);
        reading.delete();
        if (v == 0) begin
            reading.push_back('{token: TOK_ZERO, last: 1'b0});
        end else begin
            spell_group(v / 1000000000, TOK_BILLION, 1'b1);
            spell_group((v / 1000000) % 1000, TOK_MILLION, 1'b1);
            spell_group((v / 1000) % 1000, TOK_THOUSAND, 1'b1);
            spell_group(v % 1000, TOK_ZERO, 1'b0);
        end
        reading[reading.size() - 1].last = 1'b1;
        foreach (reading[k]) words_due.push_back(reading[k]);
    endfunction

    // Mix of full-range values, small values and values with zero or odd groups.
    function automatic logic [NUM_W-1:0] pick_number();
        int unsigned v;
        int unsigned grp [4];
        case ($urandom_range(3))
            0: v = $urandom & NUM_MAX;
            1: v = $urandom_range(999);
            default: begin
                foreach (grp[g]) begin
                    case ($urandom_range(4))
                        0: grp[g] = 0;
                        1: grp[g] = $urandom_range(19);
                        2: grp[g] = $urandom_range(9) * 100 + $urandom_range(20, 99);
                        3: grp[g] = $urandom_range(9) * 100;
                        default: grp[g] = $urandom_range(999);
                    endcase
                end
                v = (grp[0] % 3) * 1000000000 + grp[1] * 1000000 + grp[2] * 1000 + grp[3];
                if (v > NUM_MAX) v = v - 1000000000;
            end
        endcase
        return NUM_W'(v);
    endfunction

    // Entered and left just after a falling edge; hold the beat until it is taken.
    task automatic send_number(input logic [NUM_W-1:0] num, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start    = 1'b1;
        i_number = num;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        spell_number(num);
        @(negedge i_clk);
    endtask

    task automatic drain_words();
        start = 1'b0;
        while (words_due.size() != 0) @(negedge i_clk);
    endtask

    task automatic run_random(input int count, input int idle_pct);
        repeat (count) send_number(pick_number(), idle_pct);
    endtask

    task automatic test_directed();
        logic [NUM_W-1:0] vals [$];
        vals = '{0, 1, 9, 10, 11, 19, 20, 21, 99, 100, 101, 110, 999, 1000, 1001, 12345,
                 120012, 1000000, 700000070, 1000000000, 1000001000, 1010101010,
                 1234567891, 2000000000, 2147483647};
        foreach (vals[k]) send_number(vals[k], 0);
    endtask

    task automatic test_sender_light_idle();
        run_random(70, 6);
    endtask

    task automatic test_sender_heavy_idle();
        run_random(70, 71);
    endtask

    task automatic test_back_to_back();
        run_random(60, 0);
    endtask

    // Stop sending until every word is out, then resume from an empty pipe.
    task automatic test_pause_for_drain();
        run_random(5, 0);
        drain_words();
        run_random(5, 0);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (words_due.size() == 0) begin
                $error("unexpected word: word_token %0d last_word %0d",
                       o_word_token, o_last_word);
                err_count++;
            end else begin
                if (o_word_token !== words_due[0].token) begin
                    $error("word_token: expected %0d, actual %0d",
                           words_due[0].token, o_word_token);
                    err_count++;
                end
                if (o_last_word !== words_due[0].last) begin
                    $error("last_word: expected %0d, actual %0d",
                           words_due[0].last, o_last_word);
                    err_count++;
                end
                void'(words_due.pop_front());
            end
        end
    end

    // Count cycles in which no beat moves on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        err_count    = 0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_number     = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_sender_light_idle();
        test_sender_heavy_idle();
        test_pause_for_drain();
        test_back_to_back();

        drain_words();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
